// File: design/tdw_pkg.sv
// ----------------------------------------------------------------------------
// tdw_pkg
// Shared types and codes for the tick delay waiter table: request and reply
// words, reply kinds, controller states and the command/status groups.
// ----------------------------------------------------------------------------
package tdw_pkg;

	localparam logic [1:0] REQ_TIME  = 2'd0;
	localparam logic [1:0] REQ_DELAY = 2'd1;
	localparam logic [1:0] REQ_UNTIL = 2'd2;
	localparam logic [1:0] REQ_TICK  = 2'd3;

	localparam logic [2:0] KIND_TIME   = 3'd0;
	localparam logic [2:0] KIND_TICK   = 3'd1;
	localparam logic [2:0] KIND_DELAY  = 3'd2;
	localparam logic [2:0] KIND_UNTIL  = 3'd3;
	localparam logic [2:0] KIND_REJECT = 3'd4;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [31:0] tick_arg;
		logic [7:0]  requester_id;
	} req_t;

	typedef struct packed {
		logic [7:0]  reply_to;
		logic [2:0]  reply_kind;
		logic [31:0] tick_value;
		logic        last_reply;
	} rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic accept;
		logic step;
		logic push_last;
	} cmd_t;

	typedef struct packed {
		logic in_scan;
		logic in_stay;
		logic release_hit;
		logic scan_last;
		logic out_free;
	} sts_t;

endpackage

// File: design/tdw_ram.sv
// ----------------------------------------------------------------------------
// tdw_ram
// Generic single-write, single-read RAM with a registered read port. The
// read data holds while no read is issued.
// ----------------------------------------------------------------------------
module tdw_ram #(
	parameter int WIDTH = 42,
	parameter int DEPTH = 32
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: design/tdw_ctrl.sv
// ----------------------------------------------------------------------------
// tdw_ctrl
// Controller: takes a request word, steps the datapath through the waiter
// scan after a tick, and hands over the final reply.
// ----------------------------------------------------------------------------
module tdw_ctrl import tdw_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					if (sts.in_scan) begin
						state_d = ST_SCAN;
					end else if (!sts.in_stay) begin
						state_d = ST_FLUSH;
					end
				end
			end
			ST_SCAN: begin
				if ((!sts.release_hit || sts.out_free) && sts.scan_last) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req_ready     = 1'b0;
		cmd.accept    = 1'b0;
		cmd.step      = 1'b0;
		cmd.push_last = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready  = 1'b1;
				cmd.accept = req_valid;
			end
			// A release needs the output register free, since it pushes the
			// previous pending reply out.
			ST_SCAN: cmd.step = !sts.release_hit || sts.out_free;
			ST_FLUSH: cmd.push_last = sts.out_free;
			default: begin
				req_ready = 1'b0;
			end
		endcase
	end

endmodule

// File: design/tdw_dp.sv
// ----------------------------------------------------------------------------
// tdw_dp
// Datapath: tick counter, waiter table in RAM kept packed in insertion
// order, scan and compaction counters, pending reply and output register.
// ----------------------------------------------------------------------------
module tdw_dp import tdw_pkg::*; #(
	parameter int WAITER_SLOTS = 32,
	parameter int ID_BITS      = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  req_t req,
	input  cmd_t cmd,
	output sts_t sts,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	localparam int CNT_W  = $clog2(WAITER_SLOTS + 1);
	localparam int IDX_W  = WAITER_SLOTS > 1 ? $clog2(WAITER_SLOTS) : 1;
	localparam int ENT_W  = 32 + ID_BITS + 2;
	localparam int WIDE_W = ID_BITS > 8 ? ID_BITS : 8;

	logic [31:0]      tick_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] idx_q;
	logic [CNT_W-1:0] kept_q;
	logic             rsp_valid_q;
	rsp_t             pend_q;
	rsp_t             rsp_q;

	logic [ENT_W-1:0] rd_data;
	logic [ENT_W-1:0] wr_data;
	logic [IDX_W-1:0] wr_addr;
	logic [IDX_W-1:0] rd_addr;
	logic             wr_en;
	logic             rd_en;

	logic             is_tick;
	logic             is_delay;
	logic             full;
	logic [31:0]      tick_inc;
	logic [31:0]      new_deadline;
	logic [1:0]       new_kind;
	logic [WIDE_W-1:0] who_wide;
	logic [WIDE_W-1:0] ent_id_wide;
	logic [31:0]      ent_deadline;
	logic [1:0]       ent_kind;
	logic [CNT_W-1:0] idx_plus;
	logic             hit;
	logic             last;
	logic             load_rsp;
	rsp_t             rel_word;

	assign is_tick  = req.req_type == REQ_TICK;
	assign is_delay = req.req_type == REQ_DELAY || req.req_type == REQ_UNTIL;
	assign full     = cnt_q == CNT_W'(WAITER_SLOTS);
	assign tick_inc = tick_q + 32'd1;

	assign new_deadline = (req.req_type == REQ_DELAY) ? tick_q + req.tick_arg : req.tick_arg;
	assign new_kind     = (req.req_type == REQ_DELAY) ? KIND_DELAY[1:0] : KIND_UNTIL[1:0];
	assign who_wide     = WIDE_W'(req.requester_id);

	assign ent_deadline = rd_data[ENT_W-1 -: 32];
	assign ent_id_wide  = WIDE_W'(rd_data[2 +: ID_BITS]);
	assign ent_kind     = rd_data[1:0];

	assign idx_plus = idx_q + CNT_W'(1);
	assign hit      = ent_deadline <= tick_q;
	assign last     = idx_plus == cnt_q;

	always_comb begin
		rel_word.reply_to   = ent_id_wide[7:0];
		rel_word.reply_kind = {1'b0, ent_kind};
		rel_word.tick_value = tick_q;
		rel_word.last_reply = 1'b0;
	end

	// New waiters go to the end of the table; kept waiters slide down to the
	// compaction pointer, which never passes the read pointer.
	always_comb begin
		wr_en   = (cmd.accept && is_delay && !full) || (cmd.step && !hit);
		wr_addr = cmd.accept ? cnt_q[IDX_W-1:0] : kept_q[IDX_W-1:0];
		wr_data = cmd.accept ? {new_deadline, who_wide[ID_BITS-1:0], new_kind} : rd_data;
		rd_en   = (cmd.accept && is_tick) || (cmd.step && !last);
		rd_addr = cmd.accept ? '0 : idx_plus[IDX_W-1:0];
	end

	tdw_ram #(
		.WIDTH(ENT_W),
		.DEPTH(WAITER_SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	assign load_rsp = (cmd.step && hit) || cmd.push_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q      <= '0;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.accept && is_tick) begin
				tick_q <= tick_inc;
			end
			if (cmd.accept && is_delay && !full) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (cmd.step && last) begin
				cnt_q <= hit ? kept_q : kept_q + CNT_W'(1);
			end
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// The newest reply waits in the pending register until it is known
	// whether another reply follows it, which sets its last mark.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			pend_q.reply_to   <= req.requester_id;
			pend_q.tick_value <= is_tick ? tick_inc : tick_q;
			pend_q.last_reply <= 1'b0;
			case (req.req_type)
				REQ_TIME: pend_q.reply_kind <= KIND_TIME;
				REQ_TICK: pend_q.reply_kind <= KIND_TICK;
				default: pend_q.reply_kind <= KIND_REJECT;
			endcase
			idx_q  <= '0;
			kept_q <= '0;
		end
		if (cmd.step) begin
			idx_q <= idx_plus;
			if (hit) begin
				rsp_q  <= pend_q;
				pend_q <= rel_word;
			end else begin
				kept_q <= kept_q + CNT_W'(1);
			end
		end
		if (cmd.push_last) begin
			rsp_q.reply_to   <= pend_q.reply_to;
			rsp_q.reply_kind <= pend_q.reply_kind;
			rsp_q.tick_value <= pend_q.tick_value;
			rsp_q.last_reply <= 1'b1;
		end
	end

	always_comb begin
		sts.in_scan     = is_tick && cnt_q != '0;
		sts.in_stay     = is_delay && !full;
		sts.release_hit = hit;
		sts.scan_last   = last;
		sts.out_free    = !rsp_valid_q || rsp_ready;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// File: design/tick_delay_waiter_table.sv
// A time query or a rejected delay passes its single reply word through the
// pending and output registers; an accepted delay is stored with no reply.
// A tick scans the N stored waiters at one RAM read per cycle unless a
// release waits on a busy output register. One request is in work at a
// time. Reset clears the tick count, the waiter count and the output valid;
// the RAM is not cleared.
// ----------------------------------------------------------------------------
// tick_delay_waiter_table
// Tick counter with a bounded table of delayed requesters, released in
// insertion order when their deadline is reached.
// ----------------------------------------------------------------------------
module tick_delay_waiter_table import tdw_pkg::*; #(
	parameter int WAITER_SLOTS = 32,
	parameter int ID_BITS      = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	cmd_t cmd;
	sts_t sts;

	tdw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	tdw_dp #(
		.WAITER_SLOTS(WAITER_SLOTS),
		.ID_BITS     (ID_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

// File: design/tdw_chk.sv
// ----------------------------------------------------------------------------
// tdw_chk
// Port-level checks for the tick delay waiter table, bound to the top level.
// ----------------------------------------------------------------------------
module tdw_chk import tdw_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input req_t req,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp
);

	// A stalled reply word holds.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("reply word changed while stalled");

	// Time answers and rejects are always a single, final reply.
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.reply_kind == KIND_TIME || rsp.reply_kind == KIND_REJECT)
		|-> rsp.last_reply)
		else $error("single reply without last mark");

	// A tick or a time query always has replies to give, so the block is busy next.
	a_busy_after: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req.req_type == REQ_TICK || req.req_type == REQ_TIME)
		|=> !req_ready)
		else $error("request taken while replies were owed");

	// A tick acknowledge that is not final is followed by a release, never by
	// another time or tick reply.
	a_tick_not_first_time: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_ready && rsp.reply_kind == KIND_TICK && !rsp.last_reply
		|=> !(rsp_valid && (rsp.reply_kind == KIND_TIME || rsp.reply_kind == KIND_TICK)))
		else $error("tick acknowledge not followed by its releases");

endmodule

bind tick_delay_waiter_table tdw_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the tick delay waiter table: a scoreboard tracks
// tick count and stored waiters, and checks every reply word in order.
// ----------------------------------------------------------------------------
module tb import tdw_pkg::*; ();

	localparam int SLOTS       = 32;
	localparam int STALL_LIMIT = 3000;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_WAIT  = 100;

	typedef struct packed {
		logic [31:0] deadline;
		logic [7:0]  id;
		logic [2:0]  kind;
	} waiter_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	// Stimulus side
	req_t pend_q[$];
	logic [31:0] gen_ticks = '0;
	int permanent_left = 6;
	logic req_sent = 1'b0;

	// Scoreboard state
	logic [31:0] now_ticks = '0;
	waiter_t waiters[$];
	rsp_t reply_q[$];
	int taken_cnt = 0;
	int errors = 0;
	int stall_cycles = 0;
	int n_query = 0, n_delay = 0, n_until = 0, n_tick = 0;
	int n_release = 0, n_reject = 0, n_checked = 0;

	// Receiver hold-off
	int hold_left = 0;
	logic hold_done = 1'b0;

	wire calm = (taken_cnt >= 100) && (taken_cnt < 160);

	tick_delay_waiter_table dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	function automatic void push_reply(input logic [7:0] to, input logic [2:0] kind);
		rsp_t r;
		r.reply_to   = to;
		r.reply_kind = kind;
		r.tick_value = now_ticks;
		r.last_reply = 1'b0;
		reply_q.push_back(r);
	endfunction

	// Works out the reply words that one accepted request word causes.
	function automatic void predict_replies(input req_t r);
		waiter_t kept[$];
		waiter_t w;
		int first;
		first = reply_q.size();
		case (r.req_type)
			REQ_TIME: begin
				n_query++;
				push_reply(r.requester_id, KIND_TIME);
			end
			REQ_DELAY, REQ_UNTIL: begin
				if (r.req_type == REQ_DELAY)
					n_delay++;
				else
					n_until++;
				if (waiters.size() >= SLOTS) begin
					n_reject++;
					push_reply(r.requester_id, KIND_REJECT);
				end else begin
					w.deadline = (r.req_type == REQ_DELAY) ? now_ticks + r.tick_arg : r.tick_arg;
					w.id       = r.requester_id;
					w.kind     = (r.req_type == REQ_DELAY) ? KIND_DELAY : KIND_UNTIL;
					waiters.push_back(w);
				end
			end
			default: begin
				n_tick++;
				now_ticks = now_ticks + 32'd1;
				push_reply(r.requester_id, KIND_TICK);
				foreach (waiters[i]) begin
					if (waiters[i].deadline <= now_ticks) begin
						n_release++;
						push_reply(waiters[i].id, waiters[i].kind);
					end else begin
						kept.push_back(waiters[i]);
					end
				end
				waiters = kept;
			end
		endcase
		if (reply_q.size() > first)
			reply_q[reply_q.size() - 1].last_reply = 1'b1;
	endfunction

	// Prediction, checking and the stall watchdog, all on the rising edge.
	always @(posedge clk) begin
		rsp_t exp_word;
		req_sent <= req_valid && req_ready;
		if (req_valid && req_ready) begin
			predict_replies(req);
			taken_cnt <= taken_cnt + 1;
		end
		if (rsp_valid && rsp_ready) begin
			n_checked++;
			if (reply_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected reply word %h", $time, rsp);
			end else begin
				exp_word = reply_q.pop_front();
				if (rsp.reply_to !== exp_word.reply_to) begin
					errors++;
					$display("%0t: reply_to expected %0d actual %0d",
						$time, exp_word.reply_to, rsp.reply_to);
				end
				if (rsp.reply_kind !== exp_word.reply_kind) begin
					errors++;
					$display("%0t: reply_kind expected %0d actual %0d",
						$time, exp_word.reply_kind, rsp.reply_kind);
				end
				if (rsp.tick_value !== exp_word.tick_value) begin
					errors++;
					$display("%0t: tick_value expected %h actual %h",
						$time, exp_word.tick_value, rsp.tick_value);
				end
				if (rsp.last_reply !== exp_word.last_reply) begin
					errors++;
					$display("%0t: last_reply expected %b actual %b",
						$time, exp_word.last_reply, rsp.last_reply);
				end
			end
		end
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
			$display("simulation failed");
			$finish;
		end
	end

	// Request driver: a new word goes out only once the previous one is taken.
	always @(negedge clk) begin
		if (arst_n && (!req_valid || req_sent)) begin
			if (pend_q.size() > 0 && (calm || $urandom_range(99) >= 6)) begin
				req <= pend_q.pop_front();
				req_valid <= 1'b1;
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// Reply side: random stalls plus one long hold-off to back the block up.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			rsp_ready <= 1'b0;
		end else if (!hold_done && taken_cnt >= 60) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= calm || ($urandom_range(99) >= 6);
		end
	end

	task automatic add_item(input logic [1:0] kind, input logic [31:0] arg,
			input logic [7:0] id);
		req_t r;
		r.req_type     = kind;
		r.tick_arg     = arg;
		r.requester_id = id;
		pend_q.push_back(r);
		if (kind == REQ_TICK)
			gen_ticks = gen_ticks + 32'd1;
	endtask

	// Deadlines are mostly near the current count so that waiters get released;
	// only a few land far out and stay in the table for good.
	task automatic add_random_item();
		int pick;
		logic [31:0] arg;
		pick = $urandom_range(99);
		if (pick < 15) begin
			add_item(REQ_TIME, $urandom, 8'($urandom_range(255)));
		end else if (pick < 45) begin
			pick = $urandom_range(99);
			if (pick < 80)
				arg = $urandom_range(6);
			else if (pick < 92 || permanent_left == 0)
				arg = 32'hFFFF_FFFF - $urandom_range(3);
			else begin
				arg = $urandom | 32'h8000_0000;
				permanent_left--;
			end
			add_item(REQ_DELAY, arg, 8'($urandom_range(255)));
		end else if (pick < 65) begin
			pick = $urandom_range(99);
			if (pick < 85 || permanent_left == 0)
				arg = gen_ticks + $urandom_range(6) - 2;
			else begin
				arg = $urandom | 32'h8000_0000;
				permanent_left--;
			end
			add_item(REQ_UNTIL, arg, 8'($urandom_range(255)));
		end else begin
			add_item(REQ_TICK, $urandom, 8'($urandom_range(255)));
		end
	endtask

	initial begin
		// Directed: field extremes, zero and past deadlines, deadline wrap.
		add_item(REQ_TIME, 32'h0, 8'h00);
		add_item(REQ_TIME, 32'hFFFF_FFFF, 8'hFF);
		add_item(REQ_TICK, 32'h0, 8'h5A);
		add_item(REQ_DELAY, 32'h0, 8'h01);
		add_item(REQ_UNTIL, 32'h0, 8'h02);
		add_item(REQ_DELAY, 32'h1, 8'h03);
		add_item(REQ_UNTIL, 32'h3, 8'h04);
		add_item(REQ_DELAY, 32'hFFFF_FFFF, 8'h80);
		add_item(REQ_UNTIL, 32'hFFFF_FFFF, 8'hFE);
		add_item(REQ_TICK, 32'hFFFF_FFFF, 8'hA5);
		add_item(REQ_TIME, 32'h5555_AAAA, 8'h10);
		add_item(REQ_TICK, 32'h1234_5678, 8'h00);
		add_item(REQ_TICK, 32'h0, 8'hFF);
		add_item(REQ_DELAY, 32'h2, 8'h20);
		add_item(REQ_DELAY, 32'h2, 8'h21);
		add_item(REQ_UNTIL, gen_ticks + 32'd1, 8'h22);
		add_item(REQ_TICK, 32'h0, 8'h30);
		add_item(REQ_TICK, 32'h0, 8'h31);
		// Overfill the table so the tail of this burst is rejected, then drain it.
		repeat (40)
			add_item(REQ_DELAY, $urandom_range(1, 4), 8'($urandom_range(255)));
		add_item(REQ_TIME, 32'h0, 8'h77);
		repeat (5)
			add_item(REQ_TICK, $urandom, 8'($urandom_range(255)));
		repeat (150)
			add_random_item();

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pend_q.size() > 0 || req_valid)
			@(posedge clk);
		while (reply_q.size() > 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("covered %0d time queries, %0d delays, %0d absolute delays, %0d ticks",
			n_query, n_delay, n_until, n_tick);
		$display("%0d reply words checked, %0d waiter releases, %0d rejects on a full table",
			n_checked, n_release, n_reject);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// File: tick_delay_waiter_table.f
design/tdw_pkg.sv
design/tdw_ram.sv
design/tdw_ctrl.sv
design/tdw_dp.sv
design/tick_delay_waiter_table.sv
design/tdw_chk.sv
tb/tb.sv
